// ----- rtl/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and the sequencer state type of the Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  localparam int unsigned SYMBOLS_DEF    = 256;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned CODE_BITS_DEF  = 32;

  // Fixed field widths on the ports.
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QRY,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_NEXT,
    ST_ENQ_START,
    ST_ENQ_WN,
    ST_ENQ_CMP,
    ST_ENQ_LNK1,
    ST_ENQ_LNK2,
    ST_M_RD,
    ST_M_CHK,
    ST_M_GO,
    ST_M_HF,
    ST_W_START,
    ST_W_RD,
    ST_W_PROC,
    ST_W_RIGHT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/hcb_ram.sv -----
// ----------------------------------------------------------------------------
// hcb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/huffman_code_builder_core.sv -----
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Builds Huffman codes from per-symbol counts and answers code queries.
// ----------------------------------------------------------------------------
// Usage: the input stream carries load and query transfers, chosen by in_tuser.
// A load writes the count of one symbol. A load with
// in_tlast set also starts the tree build: the sequencer scans the count
// table, inserts each leaf into a frequency-ordered linked list kept in node
// memory, merges the two front nodes until one remains, then walks the tree
// from the root down to write code values and lengths. The build is driven by
// one list walker over simple dual-port node memories, and in_tready stays
// low until the build is done.
// A query is accepted in ST_IDLE and its result is loaded into the output
// register from ST_QRY; the block takes no new transfer until that result
// sits in the output register. If the receiver stalls, the result is held in
// the output register; the block returns to ST_IDLE, but a further query waits
// in ST_QRY with in_tready low until the result is taken.
// Reset clears the count valid flags, the present flags and the output valid flag;
// node memories need no clearing since every build writes them before use.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_core #(
  parameter int unsigned SYMBOLS    = hcb_pkg::SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS = hcb_pkg::COUNT_BITS_DEF,
  parameter int unsigned CODE_BITS  = hcb_pkg::CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // symbol [7:0], symbol_count [39:8]
  input  wire logic [0:0]  in_tuser,   // opcode [0]
  input  wire logic        in_tlast,   // last_load
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // symbol_out [7:0], code_value [39:8],
                                       // code_length [47:40]
  output logic      [0:0]  out_tuser   // present [0]
);

  localparam int unsigned SB    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned NODES = 2 * SYMBOLS - 1;
  localparam int unsigned NB    = $clog2(NODES);
  localparam int unsigned FB    = COUNT_BITS + SB;
  localparam int unsigned LW    = hcb_pkg::LEN_W;
  localparam int unsigned WW    = CODE_BITS + LW;
  localparam logic [NB-1:0] NIL = {NB{1'b1}};

  // Input field split.
  logic [hcb_pkg::SYM_W-1:0] in_sym;
  logic [hcb_pkg::CNT_W-1:0] in_cnt;
  logic                      in_op;
  logic                      in_fire;
  logic                      in_range;

  assign in_sym   = in_tdata[7:0];
  assign in_cnt   = in_tdata[39:8];
  assign in_op    = in_tuser[0];
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = {1'b0, in_sym} < 9'(SYMBOLS);

  // Sequencer registers.
  hcb_pkg::state_t state_r, state_nxt;
  logic [SB-1:0]   i_r, i_nxt;
  logic [NB-1:0]   leaves_r, leaves_nxt;
  logic [NB-1:0]   total_r, total_nxt;
  logic [NB-1:0]   head_r, head_nxt;
  logic [FB-1:0]   head_f_r, head_f_nxt;
  logic [NB-1:0]   new_n_r, new_n_nxt;
  logic [FB-1:0]   new_f_r, new_f_nxt;
  logic [NB-1:0]   cur_r, cur_nxt;
  logic [NB-1:0]   nx_r, nx_nxt;
  logic [NB-1:0]   r_r, r_nxt;
  logic [NB-1:0]   k_r, k_nxt;
  logic            merge_r, merge_nxt;
  logic [NB-1:0]   right_r, right_nxt;
  logic [WW-1:0]   rword_r, rword_nxt;
  logic [hcb_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic [SYMBOLS-1:0] valid_r, valid_nxt;
  logic [SYMBOLS-1:0] present_r, present_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [47:0]     out_data_r, out_data_nxt;
  logic            out_pres_r, out_pres_nxt;

  // Memory ports.
  logic                  cnt_we;
  logic [SB-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  frq_we;
  logic [NB-1:0]         frq_waddr, frq_raddr;
  logic [FB-1:0]         frq_wdata, frq_rdata;
  logic                  chl_we;
  logic [NB-1:0]         chl_waddr, chl_raddr;
  logic [2*NB-1:0]       chl_wdata, chl_rdata;
  logic                  lnk_we;
  logic [NB-1:0]         lnk_waddr, lnk_raddr;
  logic [NB-1:0]         lnk_wdata, lnk_rdata;
  logic                  wlk_we;
  logic [NB-1:0]         wlk_waddr, wlk_raddr;
  logic [WW-1:0]         wlk_wdata, wlk_rdata;
  logic                  cod_we;
  logic [SB-1:0]         cod_waddr, cod_raddr;
  logic [WW-1:0]         cod_wdata, cod_rdata;

  hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  hcb_ram #(.WIDTH(FB), .DEPTH(NODES)) u_frq (
    .clk, .we(frq_we), .waddr(frq_waddr), .wdata(frq_wdata),
    .raddr(frq_raddr), .rdata(frq_rdata)
  );
  hcb_ram #(.WIDTH(2*NB), .DEPTH(NODES)) u_chl (
    .clk, .we(chl_we), .waddr(chl_waddr), .wdata(chl_wdata),
    .raddr(chl_raddr), .rdata(chl_rdata)
  );
  hcb_ram #(.WIDTH(NB), .DEPTH(NODES)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );
  hcb_ram #(.WIDTH(WW), .DEPTH(NODES)) u_wlk (
    .clk, .we(wlk_we), .waddr(wlk_waddr), .wdata(wlk_wdata),
    .raddr(wlk_raddr), .rdata(wlk_rdata)
  );
  // Code table: code value in the low bits, code length on top.
  hcb_ram #(.WIDTH(WW), .DEPTH(SYMBOLS)) u_cod (
    .clk, .we(cod_we), .waddr(cod_waddr), .wdata(cod_wdata),
    .raddr(cod_raddr), .rdata(cod_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcb_pkg::ST_IDLE;
      valid_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      head_r      <= NIL;
      leaves_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      leaves_r    <= leaves_nxt;
    end
    i_r        <= i_nxt;
    total_r    <= total_nxt;
    head_f_r   <= head_f_nxt;
    new_n_r    <= new_n_nxt;
    new_f_r    <= new_f_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    merge_r    <= merge_nxt;
    right_r    <= right_nxt;
    rword_r    <= rword_nxt;
    sym_r      <= sym_nxt;
    out_data_r <= out_data_nxt;
    out_pres_r <= out_pres_nxt;
  end

  // Walk helpers.
  logic [CODE_BITS-1:0] w_code, w_base;
  logic [LW-1:0]        w_depth, w_d1;
  logic                 w_root;
  logic [SB-1:0]        w_sym;
  logic [FB-1:0]        m_sum;
  logic                 q_pres;
  logic [CODE_BITS-1:0] q_code;

  assign w_root  = (k_r == total_r - NB'(1));
  assign w_code  = w_root ? '0 : wlk_rdata[CODE_BITS-1:0];
  assign w_depth = w_root ? '0 : wlk_rdata[WW-1:CODE_BITS];
  assign w_base  = {w_code[CODE_BITS-2:0], 1'b0};
  assign w_d1    = w_depth + LW'(1);
  assign w_sym   = chl_rdata[SB-1:0];
  assign m_sum   = head_f_r + frq_rdata;
  assign q_pres  = ({1'b0, sym_r} < 9'(SYMBOLS)) && present_r[sym_r[SB-1:0]];
  assign q_code  = cod_rdata[CODE_BITS-1:0];

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    leaves_nxt   = leaves_r;
    total_nxt    = total_r;
    head_nxt     = head_r;
    head_f_nxt   = head_f_r;
    new_n_nxt    = new_n_r;
    new_f_nxt    = new_f_r;
    cur_nxt      = cur_r;
    nx_nxt       = nx_r;
    r_nxt        = r_r;
    k_nxt        = k_r;
    merge_nxt    = merge_r;
    right_nxt    = right_r;
    rword_nxt    = rword_r;
    sym_nxt      = sym_r;
    valid_nxt    = valid_r;
    present_nxt  = present_r;
    out_data_nxt = out_data_r;
    out_pres_nxt = out_pres_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready    = (state_r == hcb_pkg::ST_IDLE);

    cnt_we    = 1'b0;
    cnt_waddr = in_sym[SB-1:0];
    cnt_wdata = COUNT_BITS'(in_cnt);
    cnt_raddr = i_r;
    frq_we    = 1'b0;
    frq_waddr = leaves_r;
    frq_wdata = FB'(cnt_rdata);
    frq_raddr = r_r;
    chl_we    = 1'b0;
    chl_waddr = leaves_r;
    chl_wdata = {NB'(0), NB'(i_r)};
    chl_raddr = k_r;
    lnk_we    = 1'b0;
    lnk_waddr = new_n_r;
    lnk_wdata = nx_r;
    lnk_raddr = head_r;
    wlk_we    = 1'b0;
    wlk_waddr = right_r;
    wlk_wdata = rword_r;
    wlk_raddr = k_r;
    cod_we    = 1'b0;
    cod_waddr = w_sym;
    cod_wdata = {w_depth, w_code};
    cod_raddr = sym_r[SB-1:0];

    unique case (state_r)
      hcb_pkg::ST_IDLE: begin
        cod_raddr = in_sym[SB-1:0];
        if (in_fire) begin
          sym_nxt = in_sym;
          if (in_op == hcb_pkg::OP_QUERY) begin
            state_nxt = hcb_pkg::ST_QRY;
          end else begin
            if (in_range) begin
              cnt_we = 1'b1;
              valid_nxt[in_sym[SB-1:0]] = 1'b1;
            end
            if (in_tlast) begin
              present_nxt = '0;
              head_nxt    = NIL;
              leaves_nxt  = '0;
              i_nxt       = '0;
              merge_nxt   = 1'b0;
              state_nxt   = hcb_pkg::ST_SC_RD;
            end
          end
        end
      end
      hcb_pkg::ST_QRY: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pres_nxt  = q_pres;
          out_data_nxt  = {q_pres ? cod_rdata[WW-1:CODE_BITS] : LW'(0),
                           q_pres ? hcb_pkg::CODE_W'(q_code) : hcb_pkg::CODE_W'(0),
                           sym_r};
          state_nxt     = hcb_pkg::ST_IDLE;
        end
      end
      hcb_pkg::ST_SC_RD: begin
        state_nxt = hcb_pkg::ST_SC_CHK;
      end
      hcb_pkg::ST_SC_CHK: begin
        if (valid_r[i_r] && (cnt_rdata != '0)) begin
          frq_we     = 1'b1;
          chl_we     = 1'b1;
          new_n_nxt  = leaves_r;
          new_f_nxt  = FB'(cnt_rdata);
          leaves_nxt = leaves_r + NB'(1);
          state_nxt  = hcb_pkg::ST_ENQ_START;
        end else begin
          state_nxt  = hcb_pkg::ST_SC_NEXT;
        end
      end
      hcb_pkg::ST_SC_NEXT: begin
        if (i_r == SB'(SYMBOLS - 1)) begin
          total_nxt = leaves_r;
          merge_nxt = 1'b1;
          state_nxt = hcb_pkg::ST_M_RD;
        end else begin
          i_nxt     = i_r + SB'(1);
          state_nxt = hcb_pkg::ST_SC_RD;
        end
      end
      // Sorted insert of node new_n_r with frequency new_f_r.
      hcb_pkg::ST_ENQ_START: begin
        if ((head_r == NIL) || (new_f_r < head_f_r)) begin
          lnk_we     = 1'b1;
          lnk_wdata  = head_r;
          head_nxt   = new_n_r;
          head_f_nxt = new_f_r;
          state_nxt  = merge_r ? hcb_pkg::ST_M_RD : hcb_pkg::ST_SC_NEXT;
        end else begin
          cur_nxt   = head_r;
          state_nxt = hcb_pkg::ST_ENQ_WN;
        end
      end
      hcb_pkg::ST_ENQ_WN: begin
        nx_nxt = lnk_rdata;
        if (lnk_rdata == NIL) begin
          state_nxt = hcb_pkg::ST_ENQ_LNK1;
        end else begin
          frq_raddr = lnk_rdata;
          state_nxt = hcb_pkg::ST_ENQ_CMP;
        end
      end
      hcb_pkg::ST_ENQ_CMP: begin
        if (frq_rdata <= new_f_r) begin
          cur_nxt   = nx_r;
          lnk_raddr = nx_r;
          state_nxt = hcb_pkg::ST_ENQ_WN;
        end else begin
          state_nxt = hcb_pkg::ST_ENQ_LNK1;
        end
      end
      hcb_pkg::ST_ENQ_LNK1: begin
        lnk_we    = 1'b1;
        state_nxt = hcb_pkg::ST_ENQ_LNK2;
      end
      hcb_pkg::ST_ENQ_LNK2: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_r;
        lnk_wdata = new_n_r;
        state_nxt = merge_r ? hcb_pkg::ST_M_RD : hcb_pkg::ST_SC_NEXT;
      end
      // Pop the two front nodes and queue their parent.
      hcb_pkg::ST_M_RD: begin
        state_nxt = (head_r == NIL) ? hcb_pkg::ST_W_START : hcb_pkg::ST_M_CHK;
      end
      hcb_pkg::ST_M_CHK: begin
        if (lnk_rdata == NIL) begin
          state_nxt = hcb_pkg::ST_W_START;
        end else begin
          r_nxt     = lnk_rdata;
          frq_raddr = lnk_rdata;
          lnk_raddr = lnk_rdata;
          state_nxt = hcb_pkg::ST_M_GO;
        end
      end
      hcb_pkg::ST_M_GO: begin
        frq_we    = 1'b1;
        frq_waddr = total_r;
        frq_wdata = m_sum;
        chl_we    = 1'b1;
        chl_waddr = total_r;
        chl_wdata = {head_r, r_r};
        new_n_nxt = total_r;
        new_f_nxt = m_sum;
        total_nxt = total_r + NB'(1);
        head_nxt  = lnk_rdata;
        frq_raddr = lnk_rdata;
        state_nxt = (lnk_rdata == NIL) ? hcb_pkg::ST_ENQ_START : hcb_pkg::ST_M_HF;
      end
      hcb_pkg::ST_M_HF: begin
        head_f_nxt = frq_rdata;
        state_nxt  = hcb_pkg::ST_ENQ_START;
      end
      // Top-down walk: parents always sit above their children.
      hcb_pkg::ST_W_START: begin
        if (total_r == '0) begin
          state_nxt = hcb_pkg::ST_FIN;
        end else begin
          k_nxt     = total_r - NB'(1);
          state_nxt = hcb_pkg::ST_W_RD;
        end
      end
      hcb_pkg::ST_W_RD: begin
        state_nxt = hcb_pkg::ST_W_PROC;
      end
      hcb_pkg::ST_W_PROC: begin
        if (k_r < leaves_r) begin
          cod_we = 1'b1;
          present_nxt[w_sym] = 1'b1;
          k_nxt     = k_r - NB'(1);
          state_nxt = (k_r == '0) ? hcb_pkg::ST_FIN : hcb_pkg::ST_W_RD;
        end else begin
          wlk_we    = 1'b1;
          wlk_waddr = chl_rdata[2*NB-1:NB];
          wlk_wdata = {w_d1, w_base};
          right_nxt = chl_rdata[NB-1:0];
          rword_nxt = {w_d1, w_base | CODE_BITS'(1)};
          state_nxt = hcb_pkg::ST_W_RIGHT;
        end
      end
      hcb_pkg::ST_W_RIGHT: begin
        wlk_we    = 1'b1;
        k_nxt     = k_r - NB'(1);
        state_nxt = (k_r == '0) ? hcb_pkg::ST_FIN : hcb_pkg::ST_W_RD;
      end
      hcb_pkg::ST_FIN: begin
        valid_nxt = '0;
        state_nxt = hcb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hcb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pres_r;

`ifndef SYNTHESIS
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hcb_pkg::ST_QRY))
    else $error("result appeared without a query");
  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == hcb_pkg::ST_FIN) |-> (valid_r == '0))
    else $error("count table not cleared after build");
  a_leaf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    leaves_r <= NB'(SYMBOLS))
    else $error("leaf count out of range");
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pres_r) |-> (out_data_r[47:8] == '0))
    else $error("absent symbol reports a code");
`endif

endmodule

`default_nettype wire
